// ----- src/naive_bayes_count_classify_core_defines.svh -----
`ifndef NAIVE_BAYES_COUNT_CLASSIFY_CORE_DEFINES_SVH
`define NAIVE_BAYES_COUNT_CLASSIFY_CORE_DEFINES_SVH

// Invariant check, clocked on clk, off during reset.
`define NBC_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication check, same clocking.
`define NBC_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/nbc_pkg.sv -----
`timescale 1ns / 1ps

package nbc_pkg;

	localparam int MAX_CLASSES_D    = 8;
	localparam int MAX_ATTRIBUTES_D = 64;
	localparam int MAX_VALUES_D     = 16;
	localparam int COUNT_BITS_D     = 24;

	// register map
	localparam logic [1:0] REG_ESS     = 2'd0;
	localparam logic [1:0] REG_VALUES  = 2'd1;
	localparam logic [1:0] REG_CLASSES = 2'd2;
	localparam logic [1:0] REG_ATTRS   = 2'd3;

	localparam logic [7:0] ESS_RST     = 8'd3;
	localparam logic [4:0] VALUES_RST  = 5'd10;
	localparam logic [3:0] CLASSES_RST = 4'd2;
	localparam logic [6:0] ATTRS_RST   = 7'd4;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	localparam logic signed [31:0] SCORE_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] SCORE_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [2:0] {
		LN_IDLE,
		LN_NORM,
		LN_SQR,
		LN_MUL,
		LN_DONE
	} ln_state_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_TR_RD,
		S_TR_WR,
		S_CL_RD,
		S_CL_NUM,
		S_CL_DEN,
		S_CL_L1,
		S_CL_W1,
		S_CL_L2,
		S_CL_W2,
		S_END,
		S_FIN_RD,
		S_FIN_L,
		S_FIN_W,
		S_OUT
	} seq_state_t;

	// clamp a wide sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
		logic signed [31:0] r;
		if (s > 34'(SCORE_MAX))
			r = SCORE_MAX;
		else if (s < 34'(SCORE_MIN))
			r = SCORE_MIN;
		else
			r = s[31:0];
		return r;
	endfunction

	// score add: the minimum absorbs everything
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [33:0] b);
		logic signed [31:0] r;
		if (a == SCORE_MIN)
			r = SCORE_MIN;
		else
			r = sat32(34'(a) + b);
		return r;
	endfunction

endpackage

// ----- src/nbc_ln.sv -----
`timescale 1ns / 1ps

// Natural log in Q16 of an unsigned integer >= 1.
module nbc_ln #(
	parameter int XW = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [XW-1:0] x,
	output logic          busy,
	output logic          done,
	output logic [31:0]   result
);
	import nbc_pkg::*;

	localparam int EW = $clog2(XW);
	localparam int LW = EW + 16;
	localparam int PW = LW + 32;

	ln_state_t state_q, state_d;

	logic [XW-1:0]    x_q;
	logic [EW-1:0]    e_q;
	logic [30:0]      y_q;
	logic [15:0]      frac_q;
	logic [3:0]       it_q;
	logic [PW-1:0]    prod_q;
	logic [XW+30:0]   ext;
	logic [61:0]      sq;
	logic [PW:0]      rnd;

	assign ext = {x_q, 31'b0};
	assign sq  = y_q * y_q;
	assign rnd = {1'b0, prod_q} + (PW+1)'(64'h8000_0000);
	assign result = 32'(rnd >> 32);

	always_comb begin
		state_d = state_q;
		case (state_q)
			LN_IDLE: if (start) state_d = LN_NORM;
			LN_NORM: if (x_q[XW-1]) state_d = LN_SQR;
			LN_SQR:  if (it_q == 4'd15) state_d = LN_MUL;
			LN_MUL:  state_d = LN_DONE;
			LN_DONE: state_d = LN_IDLE;
			default: state_d = LN_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			LN_IDLE: busy = 1'b0;
			LN_DONE: done = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= LN_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			LN_IDLE: begin
				x_q <= x;
				e_q <= EW'(XW - 1);
			end
			LN_NORM: begin
				if (x_q[XW-1]) begin
					// Q1.30 mantissa from the top bits
					y_q    <= ext[XW+30:XW];
					frac_q <= '0;
					it_q   <= '0;
				end else begin
					x_q <= x_q << 1;
					e_q <= e_q - EW'(1);
				end
			end
			LN_SQR: begin
				it_q <= it_q + 4'd1;
				if (sq[61]) begin
					y_q    <= sq[61:31];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					y_q    <= sq[60:30];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			LN_MUL: prod_q <= PW'({e_q, frac_q}) * PW'(LN2_Q32);
			default: ;
		endcase
	end

endmodule

// ----- src/nbc_count_ram.sv -----
`timescale 1ns / 1ps

// Count table: one address shared by a write port and a registered read port.
module nbc_count_ram #(
	parameter int AW = 13,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule

// ----- src/naive_bayes_count_classify_core.sv -----
`timescale 1ns / 1ps

// Discrete naive Bayes with m-estimate smoothing. Rows stream in one attribute
// value per word, row end on s_tlast, s_tuser selects train (0) or classify (1).
// A classify row returns one word: best class, its log score and the saturated
// sum of all scores, Q15.16. Work is done by one shared log unit (leading-one
// shift, 16 squarings, one multiply) under a sequencer, one word at a time.
// After reset the count table is swept to zero, one entry a cycle, all 2**AW
// entries (8192 at defaults), s_tready low meanwhile. An in-range train word
// reads its count and writes it back incremented, saturating. A classify word
// takes, per class with samples, two logs (none when the numerator is zero);
// the row-end word of a classify row adds one log per class with samples.
// Config is accepted every cycle and must only be written while the core is idle.
module naive_bayes_count_classify_core #(
	parameter int MAX_CLASSES    = nbc_pkg::MAX_CLASSES_D,
	parameter int MAX_ATTRIBUTES = nbc_pkg::MAX_ATTRIBUTES_D,
	parameter int MAX_VALUES     = nbc_pkg::MAX_VALUES_D,
	parameter int COUNT_BITS     = nbc_pkg::COUNT_BITS_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] attr_value, [6:4] class_label
	input  logic        s_tlast,   // row_last
	input  logic [0:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [2:0] best_class, [34:3] best_score, [66:35] total_score
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import nbc_pkg::*;

`include "naive_bayes_count_classify_core_defines.svh"

	localparam int CW  = $clog2(MAX_CLASSES);
	localparam int NB  = $clog2(MAX_CLASSES + 1);
	localparam int AIW = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
	localparam int PB  = $clog2(MAX_ATTRIBUTES + 1);
	localparam int VW  = $clog2(MAX_VALUES);
	localparam int VB  = $clog2(MAX_VALUES + 1);
	localparam int AW  = CW + AIW + VW;
	localparam int XW  = COUNT_BITS + 1 + VB;
	localparam int MW  = COUNT_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	seq_state_t state_q, state_d;

	// config registers
	logic [7:0] ess_q;
	logic [4:0] values_q;
	logic [3:0] classes_q;
	logic [6:0] attrs_q;

	// latched input word
	logic       op_q, last_q;
	logic [3:0] val_q;
	logic [2:0] cls_q;

	logic [PB-1:0]         pos_q;
	logic [NB-1:0]         c_q;
	logic [AW-1:0]         clr_q;
	logic [COUNT_BITS-1:0] cc_q    [MAX_CLASSES];
	logic signed [31:0]    score_q [MAX_CLASSES];
	logic [XW-1:0]         num_q, den_q;
	logic [31:0]           lnnum_q;
	logic [NB-1:0]         best_q;
	logic signed [31:0]    best_s_q, total_q;
	logic [2:0]            out_cls_q;
	logic signed [31:0]    out_best_q, out_total_q;
	logic                  m_tvalid_q;

	// effective config
	logic [VB-1:0] nv;
	logic [NB-1:0] nc;
	logic          active, val_ok, cls_ok, c_done;

	logic [CW-1:0]         cidx;
	logic [COUNT_BITS-1:0] cc_sel, cnt, mem_rdata, mem_wdata;
	logic [AW-1:0]         mem_addr;
	logic                  mem_we;
	logic [MW-1:0]         mul_a;
	logic [XW-1:0]         mul_res;

	logic          ln_start, ln_busy, ln_done;
	logic [XW-1:0] ln_x;
	logic [31:0]   ln_res;

	logic signed [33:0] term;
	logic signed [31:0] s_fin;
	logic               fold;

	always_comb begin
		if (values_q == '0)
			nv = VB'(1);
		else if (32'(values_q) > MAX_VALUES)
			nv = VB'(MAX_VALUES);
		else
			nv = VB'(values_q);
		if (classes_q == '0)
			nc = NB'(1);
		else if (32'(classes_q) > MAX_CLASSES)
			nc = NB'(MAX_CLASSES);
		else
			nc = NB'(classes_q);
	end

	assign active = (32'(pos_q) < MAX_ATTRIBUTES) && (32'(pos_q) < 32'(attrs_q));
	assign val_ok = 32'(val_q) < 32'(nv);
	assign cls_ok = 32'(cls_q) < 32'(nc);
	assign c_done = c_q >= nc;
	assign cidx   = c_q[CW-1:0];
	assign cc_sel = cc_q[cidx];
	assign cnt    = val_ok ? mem_rdata : '0;

	// shared small multiplier: count*V + m, then (classcount + m)*V
	assign mul_a   = (state_q == S_CL_NUM) ? {1'b0, cnt} : (MW'(cc_sel) + MW'(ess_q));
	assign mul_res = XW'(mul_a * nv) + ((state_q == S_CL_NUM) ? XW'(ess_q) : '0);

	assign term  = 34'($signed({2'b0, lnnum_q})) - 34'($signed({2'b0, ln_res}));
	assign s_fin = (state_q == S_FIN_RD) ? SCORE_MIN
			: sat_add(score_q[cidx], 34'($signed({2'b0, ln_res})));
	assign fold  = ((state_q == S_FIN_RD) && !c_done && (cc_sel == '0))
			|| ((state_q == S_FIN_W) && ln_done);

	always_comb begin
		if (state_q == S_CLEAR)
			mem_addr = clr_q;
		else if ((state_q == S_TR_RD) || (state_q == S_TR_WR))
			mem_addr = {CW'(cls_q), pos_q[AIW-1:0], VW'(val_q)};
		else
			mem_addr = {cidx, pos_q[AIW-1:0], VW'(val_q)};
	end
	assign mem_wdata = (state_q == S_CLEAR) ? '0
			: ((mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 1'b1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (&clr_q) state_d = S_IDLE;
			S_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser[0] == 1'b0) begin
						if (active && (32'(s_tdata[6:4]) < 32'(nc))
								&& (32'(s_tdata[3:0]) < 32'(nv)))
							state_d = S_TR_RD;
						else
							state_d = S_END;
					end else if (active)
						state_d = S_CL_RD;
					else
						state_d = S_END;
				end
			end
			S_TR_RD: state_d = S_TR_WR;
			S_TR_WR: state_d = S_END;
			S_CL_RD: begin
				if (c_done)
					state_d = S_END;
				else if (cc_sel != '0)
					state_d = S_CL_NUM;
			end
			S_CL_NUM: state_d = S_CL_DEN;
			S_CL_DEN: state_d = (num_q == '0) ? S_CL_RD : S_CL_L1;
			S_CL_L1:  state_d = S_CL_W1;
			S_CL_W1:  if (ln_done) state_d = S_CL_L2;
			S_CL_L2:  state_d = S_CL_W2;
			S_CL_W2:  if (ln_done) state_d = S_CL_RD;
			S_END:    state_d = (last_q && op_q) ? S_FIN_RD : S_IDLE;
			S_FIN_RD: begin
				if (c_done)
					state_d = S_OUT;
				else if (cc_sel != '0)
					state_d = S_FIN_L;
			end
			S_FIN_L:  state_d = S_FIN_W;
			S_FIN_W:  if (ln_done) state_d = S_FIN_RD;
			S_OUT:    if (!m_tvalid_q || m_tready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		ln_start = 1'b0;
		ln_x     = num_q;
		case (state_q)
			S_IDLE:  s_tready = 1'b1;
			S_CLEAR: mem_we = 1'b1;
			S_TR_WR: mem_we = 1'b1;
			S_CL_L1: ln_start = 1'b1;
			S_CL_L2: begin
				ln_start = 1'b1;
				ln_x     = den_q;
			end
			S_FIN_L: begin
				ln_start = 1'b1;
				ln_x     = XW'(cc_sel);
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = {5'b0, out_total_q, out_best_q, out_cls_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			ess_q      <= ESS_RST;
			values_q   <= VALUES_RST;
			classes_q  <= CLASSES_RST;
			attrs_q    <= ATTRS_RST;
			pos_q      <= '0;
			c_q        <= '0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < MAX_CLASSES; i++) begin
				cc_q[i]    <= '0;
				score_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;

			if (cfg_valid) begin
				case (cfg_index)
					REG_ESS:     ess_q     <= cfg_data;
					REG_VALUES:  values_q  <= cfg_data[4:0];
					REG_CLASSES: classes_q <= cfg_data[3:0];
					REG_ATTRS:   attrs_q   <= cfg_data[6:0];
					default: ;
				endcase
			end

			// S_OUT reloads the output register itself
			if (m_tvalid_q && m_tready && (state_q != S_OUT))
				m_tvalid_q <= 1'b0;

			case (state_q)
				S_CLEAR: clr_q <= clr_q + 1'b1;
				S_IDLE:  c_q <= '0;
				S_CL_RD: if (!c_done && (cc_sel == '0)) c_q <= c_q + 1'b1;
				S_CL_DEN: begin
					if (num_q == '0) begin
						score_q[cidx] <= SCORE_MIN;
						c_q <= c_q + 1'b1;
					end
				end
				S_CL_W2: begin
					if (ln_done) begin
						score_q[cidx] <= sat_add(score_q[cidx], term);
						c_q <= c_q + 1'b1;
					end
				end
				S_END: begin
					c_q <= '0;
					if (!op_q && last_q && cls_ok && (cc_q[CW'(cls_q)] != COUNT_MAX))
						cc_q[CW'(cls_q)] <= cc_q[CW'(cls_q)] + 1'b1;
					if (!last_q) begin
						if (32'(pos_q) < MAX_ATTRIBUTES)
							pos_q <= pos_q + 1'b1;
					end else if (!op_q) begin
						pos_q <= '0;
						for (int i = 0; i < MAX_CLASSES; i++)
							score_q[i] <= '0;
					end
				end
				S_FIN_RD: if (fold) c_q <= c_q + 1'b1;
				S_FIN_W:  if (fold) c_q <= c_q + 1'b1;
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						pos_q      <= '0;
						for (int i = 0; i < MAX_CLASSES; i++)
							score_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q   <= s_tuser[0];
			val_q  <= s_tdata[3:0];
			cls_q  <= s_tdata[6:4];
			last_q <= s_tlast;
		end
		if (state_q == S_CL_NUM)
			num_q <= mul_res;
		if (state_q == S_CL_DEN)
			den_q <= mul_res;
		if ((state_q == S_CL_W1) && ln_done)
			lnnum_q <= ln_res;
		if (state_q == S_END) begin
			total_q  <= '0;
			best_q   <= '0;
			best_s_q <= '0;
		end
		if (fold) begin
			if ((c_q == '0) || (s_fin > best_s_q)) begin
				best_q   <= c_q;
				best_s_q <= s_fin;
			end
			total_q <= sat32(34'(total_q) + 34'(s_fin));
		end
		if ((state_q == S_OUT) && (!m_tvalid_q || m_tready)) begin
			out_cls_q   <= 3'(best_q);
			out_best_q  <= best_s_q;
			out_total_q <= total_q;
		end
	end

	nbc_count_ram #(
		.AW(AW),
		.DW(COUNT_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	nbc_ln #(
		.XW(XW)
	) u_ln (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ln_start),
		.x      (ln_x),
		.busy   (ln_busy),
		.done   (ln_done),
		.result (ln_res)
	);

	`NBC_IMPLY(a_ln_start_idle, ln_start, !ln_busy, "log unit started while busy")
	`NBC_IMPLY(a_ram_we_state, mem_we, (state_q == S_TR_WR) || (state_q == S_CLEAR), "stray count write")
	`NBC_CHECK(a_pos_range, 32'(pos_q) <= MAX_ATTRIBUTES, "attribute position overran")
	`NBC_IMPLY(a_class_loop, (state_q == S_CL_RD) || (state_q == S_FIN_RD), c_q <= nc, "class index past class count")

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import nbc_pkg::*;

	localparam logic OP_TRAIN    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;
	localparam int   SETTLE      = 2500;      // worst word: 8 classes, three logs each (classify row end)
	localparam int   LIMIT       = 6000000;
	localparam int   HOLD_CYCLES = 4000;
	localparam longint LOG_MIN   = -64'sd2147483648;
	localparam longint LOG_MAX   = 64'sd2147483647;
	localparam int   CNT_MAX     = (1 << 24) - 1;

	typedef struct {
		logic [2:0]         cls;
		logic signed [31:0] best;
		logic signed [31:0] total;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	naive_bayes_count_classify_core dut (.*);

	always #4 clk = ~clk;

	// mirror of the classifier state
	int unsigned vcount[8*64*16];
	int unsigned ccount[8];
	longint      score[8];
	int unsigned attr_pos;
	int unsigned reg_m, reg_v, reg_c, reg_a;

	verdict_t verdicts[$];
	int errors = 0;
	int cycles = 0;
	int send_gap_pct, recv_stall_pct;
	int hold_reqs = 0;
	int hold_seen = 0;
	int hold_off = 0;

	function automatic longint log_fix(longint unsigned x);
		int e;
		longint unsigned y, frac, l2;
		e = 63;
		frac = 0;
		while (e > 0 && x[e] == 1'b0)
			e--;
		y = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
		for (int i = 0; i < 16; i++) begin
			y = (y * y) >> 30;
			frac <<= 1;
			if (y >= (64'd1 << 31)) begin
				y >>= 1;
				frac |= 1;
			end
		end
		l2 = (longint'(e) << 16) | frac;
		return longint'((l2 * 64'd2977044472 + (64'd1 << 31)) >> 32);
	endfunction

	function automatic longint clamp_add(longint a, longint b);
		longint s;
		if (a == LOG_MIN)
			return LOG_MIN;
		s = a + b;
		if (s > LOG_MAX) s = LOG_MAX;
		if (s < LOG_MIN) s = LOG_MIN;
		return s;
	endfunction

	function automatic int unsigned eff_v();
		return (reg_v < 1) ? 1 : (reg_v > 16) ? 16 : reg_v;
	endfunction

	function automatic int unsigned eff_c();
		return (reg_c < 1) ? 1 : (reg_c > 8) ? 8 : reg_c;
	endfunction

	function automatic int unsigned eff_a();
		return (reg_a > 64) ? 64 : reg_a;
	endfunction

	function automatic void model_reset();
		foreach (vcount[i]) vcount[i] = 0;
		foreach (ccount[i]) ccount[i] = 0;
		foreach (score[i]) score[i] = 0;
		attr_pos = 0;
		reg_m = ESS_RST;
		reg_v = VALUES_RST;
		reg_c = CLASSES_RST;
		reg_a = ATTRS_RST;
	endfunction

	// update counts/scores for one accepted word, queue a verdict at classify row end
	function automatic void model_word(logic op, int unsigned val, int unsigned cls, logic last);
		int unsigned nv, nc, s;
		longint unsigned cnt, num, den, cc;
		verdict_t vd;
		longint tot, sc, bs;
		nv = eff_v();
		nc = eff_c();
		if (op == OP_TRAIN) begin
			if (attr_pos < eff_a() && cls < nc && val < nv) begin
				s = (cls * 64 + attr_pos) * 16 + val;
				if (vcount[s] < CNT_MAX) vcount[s]++;
			end
			if (last && cls < nc && ccount[cls] < CNT_MAX)
				ccount[cls]++;
		end else if (attr_pos < eff_a()) begin
			for (int c = 0; c < nc; c++) begin
				cc = ccount[c];
				if (cc == 0) continue;
				cnt = (val < nv) ? vcount[(c * 64 + attr_pos) * 16 + val] : 0;
				num = cnt * nv + reg_m;
				den = (cc + reg_m) * nv;
				if (num == 0)
					score[c] = LOG_MIN;
				else
					score[c] = clamp_add(score[c], log_fix(num) - log_fix(den));
			end
		end
		if (!last) begin
			if (attr_pos < 64) attr_pos++;
			return;
		end
		if (op == OP_CLASSIFY) begin
			tot = 0;
			bs = 0;
			vd.cls = 0;
			for (int c = 0; c < nc; c++) begin
				sc = (ccount[c] == 0) ? LOG_MIN : clamp_add(score[c], log_fix(ccount[c]));
				if (c == 0 || sc > bs) begin
					vd.cls = 3'(c);
					bs = sc;
				end
				tot += sc;
				if (tot > LOG_MAX) tot = LOG_MAX;
				if (tot < LOG_MIN) tot = LOG_MIN;
			end
			vd.best = bs[31:0];
			vd.total = tot[31:0];
			verdicts.push_back(vd);
		end
		foreach (score[i]) score[i] = 0;
		attr_pos = 0;
	endfunction

	task automatic report(string what, longint want, longint got);
		$display("mismatch %s: expected %0d, got %0d", what, want, got);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		verdict_t vd;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts.size() == 0) begin
				report("unexpected word", 0, 1);
			end else begin
				vd = verdicts.pop_front();
				if (m_tdata[2:0] !== vd.cls)
					report("best_class", vd.cls, m_tdata[2:0]);
				if ($signed(m_tdata[34:3]) !== vd.best)
					report("best_score", vd.best, $signed(m_tdata[34:3]));
				if ($signed(m_tdata[66:35]) !== vd.total)
					report("total_score", vd.total, $signed(m_tdata[66:35]));
			end
		end
	end

	// receiver: random stalls, plus a counted hold-off on request
	always @(negedge clk) begin
		if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_off  <= HOLD_CYCLES - 1;
			m_tready  <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// one word in; s_tvalid stays high across back-to-back words
	task automatic send_word(logic op, int unsigned val, int unsigned cls, logic last);
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < send_gap_pct) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, cls[2:0], val[3:0]};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		model_word(op, val, cls, last);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (verdicts.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ESS:     reg_m = data;
			REG_VALUES:  reg_v = data & 8'h1F;
			REG_CLASSES: reg_c = data & 8'h0F;
			default:     reg_a = data & 8'h7F;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(int m, int v, int c, int a);
		go_quiet();
		write_reg(REG_ESS, 8'(m));
		write_reg(REG_VALUES, 8'(v));
		write_reg(REG_CLASSES, 8'(c));
		write_reg(REG_ATTRS, 8'(a));
	endtask

	task automatic send_row(logic op, int unsigned cls, int unsigned vals[]);
		foreach (vals[i])
			send_word(op, vals[i], cls, i == vals.size() - 1);
	endtask

	// classify before any training: every class empty, scores at the minimum
	task automatic test_empty_model();
		send_row(OP_CLASSIFY, 0, '{0, 1, 2, 3});
	endtask

	// in-range counts, value out of range, class out of range
	task automatic test_train_then_classify();
		send_row(OP_TRAIN, 0, '{0, 1, 2, 15});
		send_row(OP_TRAIN, 1, '{9, 9, 9, 9});
		send_row(OP_TRAIN, 7, '{3, 3});
		send_row(OP_CLASSIFY, 5, '{0, 1, 2, 15});
	endtask

	// longer row than attributes_in_use, then a row mixing both operations
	task automatic test_row_shapes();
		send_row(OP_CLASSIFY, 0, '{9, 9, 9, 9, 4, 7});
		send_word(OP_CLASSIFY, 0, 0, 1'b0);
		send_word(OP_TRAIN, 1, 1, 1'b0);
		send_word(OP_TRAIN, 2, 0, 1'b1);
		send_word(OP_CLASSIFY, 1, 0, 1'b1);
	endtask

	// m = 0: an unseen value drives the class to the minimum
	task automatic test_zero_prior();
		configure(0, 16, 8, 1);
		send_row(OP_TRAIN, 6, '{5});
		send_row(OP_CLASSIFY, 0, '{5});
		send_row(OP_CLASSIFY, 0, '{6});
	endtask

	// out-of-range register values and the upper extremes
	task automatic test_register_extremes();
		configure(255, 0, 0, 0);
		send_row(OP_TRAIN, 0, '{0});
		send_row(OP_CLASSIFY, 0, '{0});
		configure(255, 31, 15, 127);
		send_row(OP_TRAIN, 7, '{15, 14});
		send_row(OP_CLASSIFY, 0, '{15, 14});
	endtask

	function automatic int pick_value();
		return ($urandom_range(9) < 8) ? $urandom_range(eff_v() - 1) : $urandom_range(15);
	endfunction

	function automatic int pick_class();
		return ($urandom_range(9) < 8) ? $urandom_range(eff_c() - 1) : $urandom_range(7);
	endfunction

	// mostly well-formed rows, some noise and broken rows
	task automatic random_traffic(int words);
		int sent, len, cls;
		logic op;
		sent = 0;
		while (sent < words) begin
			if ($urandom_range(99) < 85) begin
				op  = ($urandom_range(99) < 65) ? OP_TRAIN : OP_CLASSIFY;
				cls = pick_class();
				len = (eff_a() == 0) ? 1 : eff_a();
				if ($urandom_range(9) == 0) len = len + $urandom_range(2);
				if ($urandom_range(9) == 0 && len > 1) len = len - 1;
				for (int i = 0; i < len; i++)
					send_word(($urandom_range(19) == 0) ? ~op : op, pick_value(), cls,
						i == len - 1);
				sent += len;
			end else begin
				send_word(1'($urandom_range(1)), $urandom_range(15), $urandom_range(7),
					1'($urandom_range(1)));
				sent++;
			end
		end
	endtask

	task automatic random_config();
		int a, c;
		c = $urandom_range(1, 8);
		a = $urandom_range(1, 6);
		if ($urandom_range(9) == 0) begin
			a = 64;
			c = $urandom_range(1, 2);
		end
		configure(($urandom_range(4) == 0) ? 0 : $urandom_range(255), $urandom_range(1, 16),
			c, a);
	endtask

	task automatic test_random_phase(int s_gap, int r_stall);
		send_gap_pct = s_gap;
		recv_stall_pct = r_stall;
		for (int k = 0; k < 4; k++) begin
			random_config();
			random_traffic(42);
		end
	endtask

	// receiver blocked for a long stretch while classify rows keep coming
	task automatic test_backpressure();
		configure(3, 4, 2, 1);
		send_gap_pct = 0;
		send_row(OP_TRAIN, 0, '{1});
		send_row(OP_TRAIN, 1, '{2});
		hold_reqs++;
		for (int i = 0; i < 8; i++)
			send_row(OP_CLASSIFY, 0, '{$urandom_range(3)});
		go_quiet();
	endtask

	initial begin
		send_gap_pct = 0;
		recv_stall_pct = 0;
		model_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_model();
		test_train_then_classify();
		test_row_shapes();
		test_zero_prior();
		test_register_extremes();
		test_random_phase(33, 73);
		test_random_phase(73, 33);
		test_random_phase(0, 0);
		test_backpressure();

		go_quiet();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
